[rtl/fuzzy_membership_evaluator_macros.svh]
// Assertion macros for the fuzzy membership evaluator checker.
// Included by rtl/fme_checker.sv; no other dependencies.
`ifndef FUZZY_MEMBERSHIP_EVALUATOR_MACROS_SVH
`define FUZZY_MEMBERSHIP_EVALUATOR_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define FME_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fme: implication check failed");

// Next-cycle implication, active through reset as well.
`define FME_ASSERT_NEXT(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fme: next-cycle check failed");

`endif

[rtl/fme_pkg.sv]
// Shared types and constants for the fuzzy membership evaluator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fme_pkg;

    // Fractional bits of the degree; one divider step per bit.
    localparam int FRAC_BITS   = 15;
    localparam int DEGREE_W    = 16;
    localparam logic [DEGREE_W-1:0] DEGREE_FULL = 16'h8000;
    localparam logic [DEGREE_W-1:0] DEGREE_ZERO = 16'h0000;

    // Accept edge to result edge: front register, queue, divider entry register,
    // one register per quotient bit, output register.
    localparam int LATENCY     = FRAC_BITS + 4;

    localparam int QUEUE_DEPTH = 2;

    // Configuration port.
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 5;
    localparam int REG_IDX_W   = 3;
    localparam logic [REG_IDX_W-1:0] REG_SHAPE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_P1    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_P2    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_P3    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_P4    = 3'd4;

    // Shape codes.
    localparam int SHAPE_W = 3;
    typedef logic [SHAPE_W-1:0] t_shape;
    localparam t_shape SHAPE_LEFT     = 3'd0;
    localparam t_shape SHAPE_RIGHT    = 3'd1;
    localparam t_shape SHAPE_TRIANGLE = 3'd2;
    localparam t_shape SHAPE_TRAP     = 3'd3;
    localparam t_shape SHAPE_INTERVAL = 3'd4;
    localparam t_shape SHAPE_SINGLE   = 3'd5;

    // Classification handed from the front to the back.
    localparam int KIND_W = 2;
    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_ZERO = 2'd0;
    localparam t_kind KIND_FULL = 2'd1;
    localparam t_kind KIND_RAMP = 2'd2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/fuzzy_membership_evaluator.sv]
// Top level of the fuzzy membership evaluator: APB register file, front end, queue
// and divider back end. Depends on fme_pkg, fme_front, fme_queue and fme_back.
`timescale 1ns / 1ps

// Usage:
//   Configuration: APB registers at byte addresses 0x00 shape_mode, 0x04 point_one,
//   0x08 point_two, 0x0C point_three, 0x10 point_four. Points are signed,
//   SAMPLE_WIDTH bits, sign-extended on read. Write only while the block is idle.
//   Input: raise i_start with i_sample; the sample is taken at an edge where
//   o_busy is low. A new sample may be taken at every edge.
//   Output: o_done strobes for one cycle with o_degree, membership in Q1.15
//   (0x8000 is full membership). Results come out in input order.
//   Path: from the accepting edge to the edge that takes the result, a sample passes
//   one classify register, one queue slot, one divider entry register,
//   15 divider stages and one output register.
//   Throughput: one sample per cycle while o_busy is low; the divider takes one
//   quotient bit per stage. The receiver cannot stall; the back end never waits,
//   so the queue stays nearly empty and o_busy stays low in normal operation.
//   Reset (synchronous, active low) clears the configuration registers to zero
//   (left shoulder, all breakpoints zero) and drops every sample in flight.
module fuzzy_membership_evaluator #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fme_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fme_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fme_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               i_start,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [fme_pkg::DEGREE_W-1:0]       o_degree
);

    localparam int ENTRY_W = fme_pkg::KIND_W + 2 * SAMPLE_WIDTH;

    fme_pkg::t_shape                r_shape;
    logic signed [SAMPLE_WIDTH-1:0] r_p1;
    logic signed [SAMPLE_WIDTH-1:0] r_p2;
    logic signed [SAMPLE_WIDTH-1:0] r_p3;
    logic signed [SAMPLE_WIDTH-1:0] r_p4;

    logic                               cfg_wr;
    logic [fme_pkg::REG_IDX_W-1:0]      cfg_idx;
    fme_pkg::t_q_status                 q_status;
    logic                               push;
    logic [ENTRY_W-1:0]                 push_entry;
    logic [ENTRY_W-1:0]                 head_entry;
    logic                               pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[fme_pkg::CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= fme_pkg::SHAPE_LEFT;
            r_p1    <= '0;
            r_p2    <= '0;
            r_p3    <= '0;
            r_p4    <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                fme_pkg::REG_SHAPE: r_shape <= pwdata[fme_pkg::SHAPE_W-1:0];
                fme_pkg::REG_P1:    r_p1    <= pwdata[SAMPLE_WIDTH-1:0];
                fme_pkg::REG_P2:    r_p2    <= pwdata[SAMPLE_WIDTH-1:0];
                fme_pkg::REG_P3:    r_p3    <= pwdata[SAMPLE_WIDTH-1:0];
                fme_pkg::REG_P4:    r_p4    <= pwdata[SAMPLE_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            fme_pkg::REG_SHAPE: prdata = fme_pkg::CFG_DATA_W'(r_shape);
            fme_pkg::REG_P1:    prdata = fme_pkg::CFG_DATA_W'(r_p1);
            fme_pkg::REG_P2:    prdata = fme_pkg::CFG_DATA_W'(r_p2);
            fme_pkg::REG_P3:    prdata = fme_pkg::CFG_DATA_W'(r_p3);
            fme_pkg::REG_P4:    prdata = fme_pkg::CFG_DATA_W'(r_p4);
            default:            prdata = '0;
        endcase
    end

    assign o_busy = q_status.full;
    assign pop    = !q_status.empty;

    fme_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_sample   (i_sample),
        .i_shape    (r_shape),
        .i_p1       (r_p1),
        .i_p2       (r_p2),
        .i_p3       (r_p3),
        .i_p4       (r_p4),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    fme_queue #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_entry),
        .i_pop    (pop),
        .o_data   (head_entry),
        .o_status (q_status)
    );

    fme_back #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (pop),
        .i_entry  (head_entry),
        .o_done   (o_done),
        .o_degree (o_degree)
    );

endmodule

[rtl/fme_front.sv]
// Front end: accepts samples and classifies them against the breakpoints.
// Emits kind, ramp numerator and denominator; depends on fme_pkg.
`timescale 1ns / 1ps

module fme_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample,
    input  fme_pkg::t_shape                       i_shape,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_p1,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_p2,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_p3,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_p4,
    input  fme_pkg::t_q_status                    i_q_status,
    output logic                                  o_push,
    output logic [fme_pkg::KIND_W+2*SAMPLE_WIDTH-1:0] o_entry
);

    logic                           r_valid;
    logic                           n_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;

    logic                           accept;
    fme_pkg::t_kind                 kind;
    logic signed [SAMPLE_WIDTH-1:0] edge_lo;
    logic signed [SAMPLE_WIDTH-1:0] edge_hi;
    logic                           rising;
    logic signed [SAMPLE_WIDTH:0]   x_ext;
    logic signed [SAMPLE_WIDTH:0]   lo_ext;
    logic signed [SAMPLE_WIDTH:0]   hi_ext;
    logic signed [SAMPLE_WIDTH:0]   num_full;
    logic signed [SAMPLE_WIDTH:0]   den_full;

    assign accept = i_start && !i_q_status.full;
    assign o_push = r_valid && !i_q_status.full;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
        end
    end

    // Tests follow a fixed order so unordered breakpoints behave predictably.
    always_comb begin
        kind    = fme_pkg::KIND_ZERO;
        edge_lo = i_p1;
        edge_hi = i_p2;
        rising  = 1'b1;
        case (i_shape)
            fme_pkg::SHAPE_LEFT: begin
                rising = 1'b0;
                if (r_sample <= i_p1) begin
                    kind = fme_pkg::KIND_FULL;
                end else if (r_sample >= i_p2) begin
                    kind = fme_pkg::KIND_ZERO;
                end else begin
                    kind = fme_pkg::KIND_RAMP;
                end
            end
            fme_pkg::SHAPE_RIGHT: begin
                if (r_sample >= i_p2) begin
                    kind = fme_pkg::KIND_FULL;
                end else if (r_sample <= i_p1) begin
                    kind = fme_pkg::KIND_ZERO;
                end else begin
                    kind = fme_pkg::KIND_RAMP;
                end
            end
            fme_pkg::SHAPE_TRIANGLE: begin
                if (r_sample <= i_p1 || r_sample >= i_p3) begin
                    kind = fme_pkg::KIND_ZERO;
                end else if (r_sample < i_p2) begin
                    kind = fme_pkg::KIND_RAMP;
                end else if (r_sample > i_p2) begin
                    kind    = fme_pkg::KIND_RAMP;
                    edge_lo = i_p2;
                    edge_hi = i_p3;
                    rising  = 1'b0;
                end else begin
                    kind = fme_pkg::KIND_FULL;
                end
            end
            fme_pkg::SHAPE_TRAP: begin
                if (r_sample <= i_p1 || r_sample >= i_p4) begin
                    kind = fme_pkg::KIND_ZERO;
                end else if (r_sample < i_p2) begin
                    kind = fme_pkg::KIND_RAMP;
                end else if (r_sample > i_p3) begin
                    kind    = fme_pkg::KIND_RAMP;
                    edge_lo = i_p3;
                    edge_hi = i_p4;
                    rising  = 1'b0;
                end else begin
                    kind = fme_pkg::KIND_FULL;
                end
            end
            fme_pkg::SHAPE_INTERVAL: begin
                if (r_sample >= i_p1 && r_sample <= i_p2) begin
                    kind = fme_pkg::KIND_FULL;
                end
            end
            fme_pkg::SHAPE_SINGLE: begin
                if (r_sample == i_p1) begin
                    kind = fme_pkg::KIND_FULL;
                end
            end
            default: begin
                kind = fme_pkg::KIND_ZERO;
            end
        endcase
    end

    // On a ramp lo < x < hi, so both differences are positive and fit the sample width.
    assign x_ext    = {r_sample[SAMPLE_WIDTH-1], r_sample};
    assign lo_ext   = {edge_lo[SAMPLE_WIDTH-1], edge_lo};
    assign hi_ext   = {edge_hi[SAMPLE_WIDTH-1], edge_hi};
    assign num_full = rising ? (x_ext - lo_ext) : (hi_ext - x_ext);
    assign den_full = hi_ext - lo_ext;

    assign o_entry = {kind, num_full[SAMPLE_WIDTH-1:0], den_full[SAMPLE_WIDTH-1:0]};

endmodule

[rtl/fme_queue.sv]
// Short queue between the front end and the divider back end.
// Depends on fme_pkg for its depth and status type.
`timescale 1ns / 1ps

module fme_queue #(
    parameter int WIDTH = 34
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output fme_pkg::t_q_status o_status
);

    localparam int DEPTH = fme_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

[rtl/fme_back.sv]
// Back end: pipelined restoring divider, one quotient bit per stage,
// and the registered result strobe. Depends on fme_pkg.
`timescale 1ns / 1ps

module fme_back #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic [fme_pkg::KIND_W+2*SAMPLE_WIDTH-1:0] i_entry,
    output logic                                      o_done,
    output logic [fme_pkg::DEGREE_W-1:0]              o_degree
);

    localparam int STEPS = fme_pkg::FRAC_BITS;
    localparam int QW    = fme_pkg::FRAC_BITS;

    logic                          r_vld  [STEPS+1];
    fme_pkg::t_kind                r_kind [STEPS+1];
    logic [SAMPLE_WIDTH-1:0]       r_rem  [STEPS+1];
    logic [SAMPLE_WIDTH-1:0]       r_den  [STEPS+1];
    logic [QW-1:0]                 r_quo  [STEPS+1];
    logic [SAMPLE_WIDTH-1:0]       n_rem  [STEPS];
    logic [QW-1:0]                 n_quo  [STEPS];
    logic                          r_done;
    logic [fme_pkg::DEGREE_W-1:0]  r_degree;
    logic [fme_pkg::DEGREE_W-1:0]  n_degree;

    // Remainder stays below the divisor, so doubling fits one extra bit.
    always_comb begin
        logic [SAMPLE_WIDTH:0] dbl;
        logic [SAMPLE_WIDTH:0] dif;
        for (int i = 0; i < STEPS; i++) begin
            dbl = {r_rem[i], 1'b0};
            dif = dbl - {1'b0, r_den[i]};
            if (dbl >= {1'b0, r_den[i]}) begin
                n_rem[i] = dif[SAMPLE_WIDTH-1:0];
                n_quo[i] = {r_quo[i][QW-2:0], 1'b1};
            end else begin
                n_rem[i] = dbl[SAMPLE_WIDTH-1:0];
                n_quo[i] = {r_quo[i][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= STEPS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int i = 0; i < STEPS; i++) begin
                r_vld[i+1] <= r_vld[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind[0] <= i_entry[fme_pkg::KIND_W+2*SAMPLE_WIDTH-1 -: fme_pkg::KIND_W];
        r_rem[0]  <= i_entry[2*SAMPLE_WIDTH-1 -: SAMPLE_WIDTH];
        r_den[0]  <= i_entry[SAMPLE_WIDTH-1:0];
        r_quo[0]  <= '0;
        for (int i = 0; i < STEPS; i++) begin
            r_kind[i+1] <= r_kind[i];
            r_rem[i+1]  <= n_rem[i];
            r_den[i+1]  <= r_den[i];
            r_quo[i+1]  <= n_quo[i];
        end
    end

    // Numerator is below the divisor on a ramp, so the quotient never reaches full.
    always_comb begin
        case (r_kind[STEPS])
            fme_pkg::KIND_FULL: n_degree = fme_pkg::DEGREE_FULL;
            fme_pkg::KIND_RAMP: n_degree = fme_pkg::DEGREE_W'(r_quo[STEPS]);
            default:            n_degree = fme_pkg::DEGREE_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_degree <= n_degree;
    end

    assign o_done   = r_done;
    assign o_degree = r_degree;

endmodule

[rtl/fme_checker.sv]
// Port-level checker for the fuzzy membership evaluator, bound to the top level.
// Depends on fme_pkg and fuzzy_membership_evaluator_macros.svh.
`timescale 1ns / 1ps
`include "fuzzy_membership_evaluator_macros.svh"

module fme_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          o_done,
    input logic [fme_pkg::DEGREE_W-1:0]  o_degree
);

    localparam int LAT = fme_pkg::LATENCY;

    // Every result traces back to a transaction a fixed number of cycles earlier.
    `FME_ASSERT_IMPLY(a_done_has_source, i_clk, i_rst_n, o_done, $past(i_rst_n && i_start && !o_busy, LAT))

    // Full membership is exactly 1.0, never above it.
    `FME_ASSERT_IMPLY(a_degree_range, i_clk, i_rst_n, o_done && o_degree[fme_pkg::DEGREE_W-1], o_degree == fme_pkg::DEGREE_FULL)

    // The back end drains every cycle, so the queue never backs up.
    `FME_ASSERT_IMPLY(a_never_busy, i_clk, i_rst_n, 1'b1, !o_busy)

    // Reset drops everything in flight.
    `FME_ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_done && !o_busy)

endmodule

bind fuzzy_membership_evaluator fme_checker u_fme_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_degree (o_degree)
);

[dv/fuzzy_membership_evaluator_test.sv]
// Self-checking testbench for fuzzy_membership_evaluator: programs shapes over APB,
// streams samples and checks each membership degree. Depends on fme_pkg and the RTL.
`timescale 1ns / 1ps

module fuzzy_membership_evaluator_test;

    localparam int SAMPLE_W      = 16;
    localparam int POINT_MAX     = 2 ** (SAMPLE_W - 1) - 1;
    localparam int POINT_MIN     = -(2 ** (SAMPLE_W - 1));
    localparam longint Q15_ONE   = longint'(1) << fme_pkg::FRAC_BITS;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 22;
    localparam int PHASE_ITEMS   = 25;
    localparam logic [fme_pkg::REG_IDX_W-1:0] REG_IDX_MAX = '1;
    localparam fme_pkg::t_shape SHAPE_SPARE_LO = fme_pkg::SHAPE_SINGLE + 3'd1;
    localparam fme_pkg::t_shape SHAPE_SPARE_HI = '1;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [fme_pkg::CFG_ADDR_W-1:0]    paddr;
    logic [fme_pkg::CFG_DATA_W-1:0]    pwdata;
    logic [fme_pkg::CFG_DATA_W-1:0]    prdata;
    logic                              pready;
    logic                              i_start;
    logic signed [SAMPLE_W-1:0]        i_sample;
    logic                              o_busy;
    logic                              o_done;
    logic [fme_pkg::DEGREE_W-1:0]      o_degree;

    fuzzy_membership_evaluator #(.SAMPLE_WIDTH(SAMPLE_W)) dut (.*);

    // Shadow of the register file.
    fme_pkg::t_shape            shape_reg;
    logic signed [SAMPLE_W-1:0] point_regs [4];

    logic [fme_pkg::DEGREE_W-1:0] pending_degrees [$];
    int                           mismatch_count;
    int                           stall_cycles;
    bit                           back_to_back;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [fme_pkg::DEGREE_W-1:0] slope_degree(longint num, longint den);
        longint q;
        if (den <= 0 || num <= 0) return fme_pkg::DEGREE_ZERO;
        q = (num * Q15_ONE) / den;
        if (q > Q15_ONE) q = Q15_ONE;
        return fme_pkg::DEGREE_W'(q);
    endfunction

    function automatic logic [fme_pkg::DEGREE_W-1:0] membership_of(
        logic signed [SAMPLE_W-1:0] s
    );
        longint x, a, b, c, d;
        x = s;
        a = point_regs[0];
        b = point_regs[1];
        c = point_regs[2];
        d = point_regs[3];
        case (shape_reg)
            fme_pkg::SHAPE_LEFT: begin
                if (x <= a) return fme_pkg::DEGREE_FULL;
                if (x >= b) return fme_pkg::DEGREE_ZERO;
                return slope_degree(b - x, b - a);
            end
            fme_pkg::SHAPE_RIGHT: begin
                if (x >= b) return fme_pkg::DEGREE_FULL;
                if (x <= a) return fme_pkg::DEGREE_ZERO;
                return slope_degree(x - a, b - a);
            end
            fme_pkg::SHAPE_TRIANGLE: begin
                if (x <= a || x >= c) return fme_pkg::DEGREE_ZERO;
                if (x < b) return slope_degree(x - a, b - a);
                if (x > b) return slope_degree(c - x, c - b);
                return fme_pkg::DEGREE_FULL;
            end
            fme_pkg::SHAPE_TRAP: begin
                if (x <= a || x >= d) return fme_pkg::DEGREE_ZERO;
                if (x < b) return slope_degree(x - a, b - a);
                if (x > c) return slope_degree(d - x, d - c);
                return fme_pkg::DEGREE_FULL;
            end
            fme_pkg::SHAPE_INTERVAL:
                return (x >= a && x <= b) ? fme_pkg::DEGREE_FULL : fme_pkg::DEGREE_ZERO;
            fme_pkg::SHAPE_SINGLE:
                return (x == a) ? fme_pkg::DEGREE_FULL : fme_pkg::DEGREE_ZERO;
            default: return fme_pkg::DEGREE_ZERO;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] to_point(int v);
        if (v > POINT_MAX) v = POINT_MAX;
        if (v < POINT_MIN) v = POINT_MIN;
        return SAMPLE_W'(v);
    endfunction

    function automatic int random_point();
        logic signed [SAMPLE_W-1:0] r;
        r = SAMPLE_W'($urandom);
        return int'(r);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (back_to_back || r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result checking, expectation capture and the stall watchdog.
    always @(posedge i_clk) begin
        logic [fme_pkg::DEGREE_W-1:0] want;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_degrees.size() == 0) begin
                    $error("degree: unexpected result %0d", o_degree);
                    mismatch_count++;
                end else begin
                    want = pending_degrees.pop_front();
                    if (o_degree !== want) begin
                        $error("degree: expected %0d, actual %0d", want, o_degree);
                        mismatch_count++;
                    end
                end
            end
            if (i_start && !o_busy) pending_degrees.push_back(membership_of(i_sample));
            if (o_done || (i_start && !o_busy) || (psel && penable && pwrite && pready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Leaves psel and penable high; release_bus drops them after the last write.
    task automatic write_reg(logic [fme_pkg::REG_IDX_W-1:0] idx,
                             logic [fme_pkg::CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            fme_pkg::REG_SHAPE: shape_reg = data[fme_pkg::SHAPE_W-1:0];
            fme_pkg::REG_P1:    point_regs[0] = data[SAMPLE_W-1:0];
            fme_pkg::REG_P2:    point_regs[1] = data[SAMPLE_W-1:0];
            fme_pkg::REG_P3:    point_regs[2] = data[SAMPLE_W-1:0];
            fme_pkg::REG_P4:    point_regs[3] = data[SAMPLE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic release_bus();
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Program all five registers; bits above each width carry junk.
    task automatic load_shape(fme_pkg::t_shape sh, int a, int b, int c, int d);
        logic [fme_pkg::CFG_DATA_W-1:0] junk;
        logic signed [SAMPLE_W-1:0] p;
        junk = $urandom;
        write_reg(fme_pkg::REG_SHAPE, {junk[fme_pkg::CFG_DATA_W-1:fme_pkg::SHAPE_W], sh});
        p = to_point(a);
        junk = $urandom;
        write_reg(fme_pkg::REG_P1, {junk[fme_pkg::CFG_DATA_W-1:SAMPLE_W], p});
        p = to_point(b);
        junk = $urandom;
        write_reg(fme_pkg::REG_P2, {junk[fme_pkg::CFG_DATA_W-1:SAMPLE_W], p});
        p = to_point(c);
        junk = $urandom;
        write_reg(fme_pkg::REG_P3, {junk[fme_pkg::CFG_DATA_W-1:SAMPLE_W], p});
        p = to_point(d);
        junk = $urandom;
        write_reg(fme_pkg::REG_P4, {junk[fme_pkg::CFG_DATA_W-1:SAMPLE_W], p});
        release_bus();
    endtask

    // Called and returns at a falling edge; start stays high when no gap follows.
    task automatic fuzzify(int s);
        int gap;
        i_start  <= 1'b1;
        i_sample <= to_point(s);
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_start <= 1'b0;
        while (pending_degrees.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_reset_state();
        fuzzify(0);
        fuzzify(1);
        fuzzify(POINT_MIN);
        wait_idle();
    endtask

    task automatic test_shoulders();
        load_shape(fme_pkg::SHAPE_LEFT, POINT_MIN, POINT_MAX, 0, 0);
        fuzzify(POINT_MIN + 1);
        fuzzify(POINT_MAX - 1);
        fuzzify(POINT_MAX);
        wait_idle();
        load_shape(fme_pkg::SHAPE_RIGHT, -100, 100, 0, 0);
        fuzzify(-100);
        fuzzify(0);
        fuzzify(100);
        wait_idle();
    endtask

    task automatic test_triangle_trapezoid();
        load_shape(fme_pkg::SHAPE_TRIANGLE, -100, 0, 100, 0);
        fuzzify(-50);
        fuzzify(0);
        fuzzify(50);
        wait_idle();
        load_shape(fme_pkg::SHAPE_TRAP, -100, -50, 50, 100);
        fuzzify(-75);
        fuzzify(0);
        fuzzify(75);
        fuzzify(100);
        wait_idle();
    endtask

    task automatic test_crisp_sets();
        load_shape(fme_pkg::SHAPE_INTERVAL, -10, 10, 0, 0);
        fuzzify(-10);
        fuzzify(10);
        fuzzify(11);
        wait_idle();
        load_shape(fme_pkg::SHAPE_SINGLE, 5, 0, 0, 0);
        fuzzify(5);
        fuzzify(4);
        wait_idle();
    endtask

    // Unused shape code, a center outside its edges, and a write past the last register.
    task automatic test_irregular_settings();
        load_shape(SHAPE_SPARE_HI, 0, 0, 0, 0);
        fuzzify(0);
        wait_idle();
        load_shape(fme_pkg::SHAPE_TRIANGLE, 0, -50, 100, 0);
        write_reg(REG_IDX_MAX, $urandom);
        release_bus();
        fuzzify(10);
        wait_idle();
    endtask

    task automatic test_random_stream();
        int pts [$];
        int kind, spread, v, r, s;
        fme_pkg::t_shape sh;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            r = $urandom_range(0, 19);
            if (r < 18)       sh = fme_pkg::t_shape'(r % 6);
            else if (r == 18) sh = SHAPE_SPARE_LO;
            else              sh = SHAPE_SPARE_HI;
            pts.delete();
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                spread = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 400);
                v = random_point();
                for (int i = 0; i < 4; i++) begin
                    pts.push_back(int'(to_point(v)));
                    v += $urandom_range(0, spread);
                end
            end else begin
                for (int i = 0; i < 4; i++) begin
                    if (kind == 8) begin
                        case ($urandom_range(0, 3))
                            0: pts.push_back(POINT_MIN);
                            1: pts.push_back(POINT_MAX);
                            2: pts.push_back(0);
                            default: pts.push_back(-1);
                        endcase
                    end else begin
                        pts.push_back(random_point());
                    end
                end
                if (kind <= 7) pts.sort();
            end
            load_shape(sh, pts[0], pts[1], pts[2], pts[3]);
            if ($urandom_range(0, 7) == 0) begin
                write_reg(REG_IDX_MAX - fme_pkg::REG_IDX_W'($urandom_range(0, 2)), $urandom);
                release_bus();
            end
            back_to_back = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 9);
                if (r <= 5) begin
                    spread = $urandom_range(0, 1) ? 3 : 300;
                    s = pts[$urandom_range(0, 3)] + $urandom_range(0, 2 * spread) - spread;
                end else if (r == 6) begin
                    s = pts[$urandom_range(0, 3)];
                end else if (r <= 8) begin
                    s = random_point();
                end else begin
                    s = $urandom_range(0, 1) ? POINT_MAX : POINT_MIN;
                end
                fuzzify(s);
            end
            back_to_back = 1'b0;
            wait_idle();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_start        = 1'b0;
        i_sample       = '0;
        shape_reg      = fme_pkg::SHAPE_LEFT;
        point_regs     = '{default: '0};
        mismatch_count = 0;
        stall_cycles   = 0;
        back_to_back   = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_shoulders();
        test_triangle_trapezoid();
        test_crisp_sets();
        test_irregular_settings();
        test_random_stream();

        // Let any stray result show up before the verdict.
        repeat (fme_pkg::LATENCY + 4) @(posedge i_clk);
        if (pending_degrees.size() != 0) begin
            $error("degree: %0d results never arrived", pending_degrees.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
